// ===== hdl/nta_pkg.sv =====
// ----------------------------------------------------------------------------
// nta_pkg
// Shared types, reset values and codes of the neighbour table with ageing.
// ----------------------------------------------------------------------------
package nta_pkg;

  localparam int unsigned TABLE_ENTRIES_DEF = 16;

  localparam int unsigned ID_W     = 32;
  localparam int unsigned TIME_W   = 32;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned FIELD_W  = 5;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 32;

  localparam logic [TIME_W-1:0] TIMEOUT_RST   = 32'd1000;
  localparam logic              EXPIRY_EN_RST = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT   = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_EXPIRY_EN = 1'd1;

  localparam logic OP_OBSERVE = 1'b0;
  localparam logic OP_TICK    = 1'b1;

  localparam logic [STATUS_W-1:0] STAT_REFRESHED = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_INSERTED  = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_FULL      = 2'd2;
  localparam logic [STATUS_W-1:0] STAT_TICK      = 2'd3;

  typedef struct packed {
    logic              valid;
    logic [ID_W-1:0]   id;
    logic [TIME_W-1:0] expiry;
  } entry_t;

  typedef struct packed {
    logic match;
    logic expired;
  } cmp_res_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [FIELD_W-1:0]  expired_count;
    logic [FIELD_W-1:0]  neighbor_count;
  } rsp_t;

endpackage

// ===== hdl/nta_in_if.sv =====
// ----------------------------------------------------------------------------
// nta_in_if
// Request channel: observe or tick, with the neighbour id.
// ----------------------------------------------------------------------------
interface nta_in_if
  import nta_pkg::*;
  ();
  logic            valid;
  logic            ready;
  logic            op;
  logic [ID_W-1:0] neighbor_id;

  modport source (output valid, output op, output neighbor_id, input ready);
  modport sink   (input valid, input op, input neighbor_id, output ready);
endinterface

// ===== hdl/nta_out_if.sv =====
// ----------------------------------------------------------------------------
// nta_out_if
// Result channel: status, expired count and live neighbour count.
// ----------------------------------------------------------------------------
interface nta_out_if
  import nta_pkg::*;
  ();
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [FIELD_W-1:0]  expired_count;
  logic [FIELD_W-1:0]  neighbor_count;

  modport source (output valid, output status, output expired_count,
                  output neighbor_count, input ready);
  modport sink   (input valid, input status, input expired_count,
                  input neighbor_count, output ready);
endinterface

// ===== hdl/nta_mem.sv =====
// ----------------------------------------------------------------------------
// nta_mem
// Neighbour table storage, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module nta_mem
  import nta_pkg::*;
#(
  parameter int unsigned DEPTH = TABLE_ENTRIES_DEF,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  entry_t        wdata,
  input  logic [AW-1:0] raddr,
  output entry_t        rdata
);

  entry_t mem [DEPTH];
  entry_t rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== hdl/nta_cmp.sv =====
// ----------------------------------------------------------------------------
// nta_cmp
// Shared compare unit: id match and wrap-aware expiry test of one entry.
// ----------------------------------------------------------------------------
module nta_cmp
  import nta_pkg::*;
(
  input  entry_t            ent,
  input  logic [ID_W-1:0]   key,
  input  logic [TIME_W-1:0] now,
  output cmp_res_t          res
);

  logic [TIME_W-1:0] diff;

  assign diff        = now - ent.expiry;
  assign res.match   = ent.valid && (ent.id == key);
  assign res.expired = ent.valid && !diff[TIME_W-1];

endmodule

// ===== hdl/nta_ctrl.sv =====
// ----------------------------------------------------------------------------
// nta_ctrl
// Sequencer: clearing pass, table scan, commit and result register.
// ----------------------------------------------------------------------------
module nta_ctrl
  import nta_pkg::*;
#(
  parameter int unsigned TABLE_ENTRIES = TABLE_ENTRIES_DEF,
  parameter int unsigned IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1,
  parameter int unsigned CNT_W = $clog2(TABLE_ENTRIES + 1)
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [TIME_W-1:0] timeout,
  input  logic              expiry_en,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              in_op,
  input  logic [ID_W-1:0]   in_id,
  output logic              out_valid,
  input  logic              out_ready,
  output rsp_t              out_rsp,
  output logic              mem_we,
  output logic [IDX_W-1:0]  mem_waddr,
  output entry_t            mem_wdata,
  output logic [IDX_W-1:0]  mem_raddr,
  input  entry_t            mem_rdata
);

  localparam logic [2:0] ST_CLEAR  = 3'd0;
  localparam logic [2:0] ST_IDLE   = 3'd1;
  localparam logic [2:0] ST_SCAN   = 3'd2;
  localparam logic [2:0] ST_COMMIT = 3'd3;
  localparam logic [2:0] ST_DONE   = 3'd4;

  localparam logic [CNT_W-1:0] LAST_ADDR = CNT_W'(TABLE_ENTRIES - 1);
  localparam logic [CNT_W-1:0] END_ADDR  = CNT_W'(TABLE_ENTRIES);

  logic [2:0]          state_r,    state_nxt;
  logic [CNT_W-1:0]    addr_r,     addr_nxt;
  logic                rd_vld_r,   rd_vld_nxt;
  logic [IDX_W-1:0]    rd_idx_r,   rd_idx_nxt;
  logic                op_r,       op_nxt;
  logic [ID_W-1:0]     id_r,       id_nxt;
  logic [TIME_W-1:0]   time_r,     time_nxt;
  logic [TIME_W-1:0]   new_exp_r,  new_exp_nxt;
  logic                hit_vld_r,  hit_vld_nxt;
  logic [IDX_W-1:0]    hit_idx_r,  hit_idx_nxt;
  logic                free_vld_r, free_vld_nxt;
  logic [IDX_W-1:0]    free_idx_r, free_idx_nxt;
  logic [CNT_W-1:0]    exp_cnt_r,  exp_cnt_nxt;
  logic [CNT_W-1:0]    live_r,     live_nxt;
  logic [STATUS_W-1:0] status_r,   status_nxt;
  logic                out_vld_r,  out_vld_nxt;
  rsp_t                rsp_r,      rsp_nxt;
  cmp_res_t            cmp;

  nta_cmp u_cmp (
    .ent (mem_rdata),
    .key (id_r),
    .now (time_r),
    .res (cmp)
  );

  always_comb begin
    state_nxt    = state_r;
    addr_nxt     = addr_r;
    rd_vld_nxt   = rd_vld_r;
    rd_idx_nxt   = rd_idx_r;
    op_nxt       = op_r;
    id_nxt       = id_r;
    time_nxt     = time_r;
    new_exp_nxt  = new_exp_r;
    hit_vld_nxt  = hit_vld_r;
    hit_idx_nxt  = hit_idx_r;
    free_vld_nxt = free_vld_r;
    free_idx_nxt = free_idx_r;
    exp_cnt_nxt  = exp_cnt_r;
    live_nxt     = live_r;
    status_nxt   = status_r;
    out_vld_nxt  = out_vld_r;
    rsp_nxt      = rsp_r;
    mem_we       = 1'b0;
    mem_waddr    = rd_idx_r;
    mem_wdata    = '0;
    mem_raddr    = addr_r[IDX_W-1:0];
    in_ready     = (state_r == ST_IDLE);

    if (out_vld_r && out_ready) begin
      out_vld_nxt = 1'b0;
    end

    case (state_r)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = addr_r[IDX_W-1:0];
        if (addr_r == LAST_ADDR) begin
          addr_nxt  = '0;
          state_nxt = ST_IDLE;
        end else begin
          addr_nxt = addr_r + 1'b1;
        end
      end
      ST_IDLE: begin
        if (in_valid) begin
          op_nxt       = in_op;
          id_nxt       = in_id;
          addr_nxt     = '0;
          rd_vld_nxt   = 1'b0;
          hit_vld_nxt  = 1'b0;
          free_vld_nxt = 1'b0;
          exp_cnt_nxt  = '0;
          new_exp_nxt  = time_r + timeout;
          if (in_op == OP_TICK) begin
            time_nxt = time_r + 1'b1;
          end
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (addr_r != END_ADDR) begin
          addr_nxt   = addr_r + 1'b1;
          rd_vld_nxt = 1'b1;
          rd_idx_nxt = addr_r[IDX_W-1:0];
        end else begin
          rd_vld_nxt = 1'b0;
        end
        if (rd_vld_r) begin
          if (op_r == OP_TICK) begin
            if (expiry_en && cmp.expired) begin
              mem_we          = 1'b1;
              mem_waddr       = rd_idx_r;
              mem_wdata       = mem_rdata;
              mem_wdata.valid = 1'b0;
              exp_cnt_nxt     = exp_cnt_r + 1'b1;
            end
          end else begin
            if (cmp.match && !hit_vld_r) begin
              hit_vld_nxt = 1'b1;
              hit_idx_nxt = rd_idx_r;
            end
            if (!mem_rdata.valid && !free_vld_r) begin
              free_vld_nxt = 1'b1;
              free_idx_nxt = rd_idx_r;
            end
          end
        end
        if (addr_r == END_ADDR && !rd_vld_r) begin
          state_nxt = ST_COMMIT;
        end
      end
      ST_COMMIT: begin
        if (op_r == OP_TICK) begin
          live_nxt   = live_r - exp_cnt_r;
          status_nxt = STAT_TICK;
        end else if (hit_vld_r) begin
          mem_we     = 1'b1;
          mem_waddr  = hit_idx_r;
          mem_wdata  = '{valid: 1'b1, id: id_r, expiry: new_exp_r};
          status_nxt = STAT_REFRESHED;
        end else if (free_vld_r) begin
          mem_we     = 1'b1;
          mem_waddr  = free_idx_r;
          mem_wdata  = '{valid: 1'b1, id: id_r, expiry: new_exp_r};
          live_nxt   = live_r + 1'b1;
          status_nxt = STAT_INSERTED;
        end else begin
          status_nxt = STAT_FULL;
        end
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (!out_vld_r || out_ready) begin
          out_vld_nxt            = 1'b1;
          rsp_nxt.status         = status_r;
          rsp_nxt.expired_count  = FIELD_W'(exp_cnt_r);
          rsp_nxt.neighbor_count = FIELD_W'(live_r);
          state_nxt              = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_CLEAR;
      addr_r    <= '0;
      rd_vld_r  <= 1'b0;
      time_r    <= '0;
      live_r    <= '0;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      addr_r    <= addr_nxt;
      rd_vld_r  <= rd_vld_nxt;
      time_r    <= time_nxt;
      live_r    <= live_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rd_idx_r   <= rd_idx_nxt;
    op_r       <= op_nxt;
    id_r       <= id_nxt;
    new_exp_r  <= new_exp_nxt;
    hit_vld_r  <= hit_vld_nxt;
    hit_idx_r  <= hit_idx_nxt;
    free_vld_r <= free_vld_nxt;
    free_idx_r <= free_idx_nxt;
    exp_cnt_r  <= exp_cnt_nxt;
    status_r   <= status_nxt;
    rsp_r      <= rsp_nxt;
  end

  assign out_valid = out_vld_r;
  assign out_rsp   = rsp_r;

  assert property (@(posedge clk) disable iff (!rst_n)
    live_r <= END_ADDR)
    else $error("live count above table size");

  assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r == ST_SCAN))
    else $error("accepted request did not start a scan");

  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_COMMIT && op_r == OP_OBSERVE && !hit_vld_r && free_vld_r)
      |=> (live_r == $past(live_r) + 1'b1))
    else $error("insert did not bump live count");

  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_COMMIT && op_r == OP_TICK) |-> (exp_cnt_r <= live_r))
    else $error("more entries expired than were live");

endmodule

// ===== hdl/neighbor_table_with_aging.sv =====
// ----------------------------------------------------------------------------
// neighbor_table_with_aging
// Fixed neighbour table with per-entry expiry on a millisecond tick clock.
// ----------------------------------------------------------------------------
// Each request (observe or tick) is handled by one pass over the table, one
// entry a cycle through the registered read port of the table memory and a
// single shared compare unit; after the scan and commit steps the result is
// registered when the result register is free, and in_req.ready rises again
// in the same cycle; a result still waiting holds the block in its last step
// until it is taken. After reset a clearing pass marks every slot free before
// the first request is taken; configuration writes are taken at any time but
// are meant for idle.
module neighbor_table_with_aging
  import nta_pkg::*;
#(
  parameter int unsigned TABLE_ENTRIES = TABLE_ENTRIES_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  nta_in_if.sink                in_req,
  nta_out_if.source             out_rsp
);

  localparam int unsigned IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int unsigned CNT_W = $clog2(TABLE_ENTRIES + 1);

  logic [TIME_W-1:0] timeout_r;
  logic              expiry_en_r;
  logic              mem_we;
  logic [IDX_W-1:0]  mem_waddr;
  logic [IDX_W-1:0]  mem_raddr;
  entry_t            mem_wdata;
  entry_t            mem_rdata;
  rsp_t              rsp;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_r   <= TIMEOUT_RST;
      expiry_en_r <= EXPIRY_EN_RST;
    end else if (cfg_we) begin
      case (cfg_idx)
        CFG_TIMEOUT:   timeout_r   <= cfg_wdata[TIME_W-1:0];
        CFG_EXPIRY_EN: expiry_en_r <= cfg_wdata[0];
        default: begin
        end
      endcase
    end
  end

  nta_mem #(
    .DEPTH (TABLE_ENTRIES),
    .AW    (IDX_W)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  nta_ctrl #(
    .TABLE_ENTRIES (TABLE_ENTRIES),
    .IDX_W         (IDX_W),
    .CNT_W         (CNT_W)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .timeout   (timeout_r),
    .expiry_en (expiry_en_r),
    .in_valid  (in_req.valid),
    .in_ready  (in_req.ready),
    .in_op     (in_req.op),
    .in_id     (in_req.neighbor_id),
    .out_valid (out_rsp.valid),
    .out_ready (out_rsp.ready),
    .out_rsp   (rsp),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata)
  );

  assign out_rsp.status         = rsp.status;
  assign out_rsp.expired_count  = rsp.expired_count;
  assign out_rsp.neighbor_count = rsp.neighbor_count;

endmodule
